/* src/bpfa_pkg.sv */
package bpfa_pkg;

	// Field and register widths
	localparam int ADDR_W     = 48;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_W      = 17;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS  = 32;
	localparam int WORD_SHIFT = 5;

	// Page number of a byte address, page count of a region, region end
	localparam int PG_W  = ADDR_W - PAGE_SHIFT;
	localparam int CNT_W = PG_W + 1;
	localparam int END_W = PG_W + 2;

	localparam int DEF_MAX_PAGES = 65536;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);

	// Rounding addend for partial pages (page size minus one)
	localparam logic [PAGE_SHIFT-1:0] PAGE_MASK = '1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOCK_ALL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESERVE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SET      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_TEST     = 3'd6;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OOM   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

endpackage

/* src/bitmap_page_frame_allocator.sv */
// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+-------------------------------------------
// in       | input     | in_valid / in_ready  | command, base_address, length_bytes
// out      | output    | out_valid / out_ready| page_address, status, page_used
// cfg      | input     | cfg_valid / cfg_ready| cfg_data (page_total)
//
// One command at a time. Each bitmap word visited takes one read and one
// read-modify-write on the single-port bitmap RAM; a region or an
// allocation scan walks one 32-page word per visit. Lock all sweeps every word at
// one per cycle. After reset the bitmap is filled with ones by a pass over every
// word, during which in_ready stays low.
// A result waits in the output register; the next command is taken meanwhile and
// holds in its last state until that register is free.
module bitmap_page_frame_allocator #(
	parameter int MAX_PAGES = bpfa_pkg::DEF_MAX_PAGES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bpfa_pkg::CMD_W-1:0]    command,
	input  logic [bpfa_pkg::ADDR_W-1:0]   base_address,
	input  logic [bpfa_pkg::ADDR_W-1:0]   length_bytes,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bpfa_pkg::ADDR_W-1:0]   page_address,
	output logic [bpfa_pkg::STATUS_W-1:0] status,
	output logic                          page_used,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpfa_pkg::CFG_W-1:0]    cfg_data
);

	localparam int Words  = (MAX_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
	localparam int AW     = $clog2(Words);
	localparam int PIW    = $clog2(MAX_PAGES);
	localparam int AddrW  = bpfa_pkg::ADDR_W;
	localparam int PgW    = bpfa_pkg::PG_W;
	localparam int CntW   = bpfa_pkg::CNT_W;
	localparam int EndW   = bpfa_pkg::END_W;
	localparam int WordW  = bpfa_pkg::WORD_BITS;
	localparam int Shift  = bpfa_pkg::PAGE_SHIFT;

	typedef enum logic [5:0] {
		ST_FILL = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_PREP = 6'b000100,
		ST_READ = 6'b001000,
		ST_MOD  = 6'b010000,
		ST_RESP = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   word_q;
	logic                            fill_reply_q;
	logic                            out_valid_q;
	logic [bpfa_pkg::CFG_W-1:0]      page_total_q;

	logic [bpfa_pkg::CMD_W-1:0]      cmd_q;
	logic [PgW-1:0]                  page_q;
	logic [CntW-1:0]                 count_q;
	logic [PIW-1:0]                  first_q;
	logic [PIW-1:0]                  last_q;
	logic [AddrW-1:0]                res_addr_q;
	logic [bpfa_pkg::STATUS_W-1:0]   res_status_q;
	logic                            res_used_q;
	logic [AddrW-1:0]                out_addr_q;
	logic [bpfa_pkg::STATUS_W-1:0]   out_status_q;
	logic                            out_used_q;

	logic [WordW-1:0]                bitmap_mem [Words];
	logic [WordW-1:0]                rdata_q;

	logic [AddrW:0]                  len_round;
	logic [CntW-1:0]                 count_in;
	logic [EndW-1:0]                 tot_e;
	logic [EndW-1:0]                 start_e;
	logic [EndW-1:0]                 end_e;
	logic [EndW-1:0]                 stop_e;
	logic                            region_hit;
	logic                            region_over;
	logic                            page_out;
	logic                            tot_zero;
	logic [AW-1:0]                   first_w;
	logic [AW-1:0]                   last_w;
	logic [bpfa_pkg::WORD_SHIFT-1:0] lo_bit;
	logic [bpfa_pkg::WORD_SHIFT-1:0] hi_bit;
	logic [WordW-1:0]                range_mask;
	logic [WordW-1:0]                free_bits;
	logic                            found;
	logic [bpfa_pkg::WORD_SHIFT-1:0] free_idx;
	logic                            mem_we;
	logic [WordW-1:0]                mem_wd;
	logic                            at_last_word;

	assign in_ready     = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign page_address = out_addr_q;
	assign status       = out_status_q;
	assign page_used    = out_used_q;

	// Page count of the incoming region: floor for free, ceiling for reserve
	assign len_round = {1'b0, length_bytes} + (AddrW + 1)'(bpfa_pkg::PAGE_MASK);
	always_comb begin
		unique case (command)
			bpfa_pkg::CMD_FREE:    count_in = {1'b0, length_bytes[AddrW-1:Shift]};
			bpfa_pkg::CMD_RESERVE: count_in = len_round[AddrW:Shift];
			bpfa_pkg::CMD_SET,
			bpfa_pkg::CMD_CLEAR:   count_in = CntW'(1);
			default:               count_in = '0;
		endcase
	end

	// Active total: configured count saturated at MAX_PAGES
	always_comb begin
		if (EndW'(page_total_q) > EndW'(MAX_PAGES)) begin
			tot_e = EndW'(MAX_PAGES);
		end else begin
			tot_e = EndW'(page_total_q);
		end
	end

	// Region bounds, clipped to the active total
	assign start_e     = EndW'(page_q);
	assign end_e       = start_e + EndW'(count_q);
	assign stop_e      = (end_e > tot_e) ? tot_e : end_e;
	assign region_hit  = (start_e < stop_e);
	assign region_over = (count_q != '0) && (end_e > tot_e);
	assign page_out    = (start_e >= tot_e);
	assign tot_zero    = (tot_e == '0);

	// Shared word unit: in-range bit mask, first free bit, merged write word
	assign first_w      = AW'(first_q >> bpfa_pkg::WORD_SHIFT);
	assign last_w       = AW'(last_q >> bpfa_pkg::WORD_SHIFT);
	assign at_last_word = (word_q == last_w);
	assign lo_bit = (word_q == first_w) ? first_q[bpfa_pkg::WORD_SHIFT-1:0] : '0;
	assign hi_bit = at_last_word ? last_q[bpfa_pkg::WORD_SHIFT-1:0] : '1;
	assign range_mask = ({WordW{1'b1}} << lo_bit) & ({WordW{1'b1}} >> (5'd31 - hi_bit));
	assign free_bits  = ~rdata_q & range_mask;
	assign found      = |free_bits;

	always_comb begin
		free_idx = '0;
		for (int i = WordW - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				free_idx = i[bpfa_pkg::WORD_SHIFT-1:0];
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wd = '1;
		if (state_q == ST_FILL) begin
			mem_we = 1'b1;
		end else if (state_q == ST_MOD) begin
			case (cmd_q) inside
				bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_CLEAR: begin
					mem_we = 1'b1;
					mem_wd = rdata_q & ~range_mask;
				end
				bpfa_pkg::CMD_RESERVE, bpfa_pkg::CMD_SET: begin
					mem_we = 1'b1;
					mem_wd = rdata_q | range_mask;
				end
				bpfa_pkg::CMD_ALLOC: begin
					mem_we = found;
					mem_wd = rdata_q | (WordW'(1) << free_idx);
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	// Bitmap RAM: one write port, one registered read port, both at word_q
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[word_q] <= mem_wd;
		end
		rdata_q <= bitmap_mem[word_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			word_q       <= '0;
			fill_reply_q <= 1'b0;
			out_valid_q  <= 1'b0;
			page_total_q <= bpfa_pkg::CFG_RESET;
		end else begin
			if (cfg_valid) begin
				page_total_q <= cfg_data;
			end
			// Output register: loaded from the response state, cleared once taken
			if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					if (word_q == AW'(Words - 1)) begin
						word_q       <= '0;
						fill_reply_q <= 1'b0;
						state_q      <= fill_reply_q ? ST_RESP : ST_IDLE;
					end else begin
						word_q <= word_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					case (cmd_q) inside
						bpfa_pkg::CMD_LOCK_ALL: begin
							word_q       <= '0;
							fill_reply_q <= 1'b1;
							state_q      <= ST_FILL;
						end
						bpfa_pkg::CMD_ALLOC: begin
							word_q  <= '0;
							state_q <= tot_zero ? ST_RESP : ST_READ;
						end
						bpfa_pkg::CMD_TEST: begin
							word_q  <= AW'(page_q >> bpfa_pkg::WORD_SHIFT);
							state_q <= page_out ? ST_RESP : ST_READ;
						end
						bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_RESERVE,
						bpfa_pkg::CMD_SET, bpfa_pkg::CMD_CLEAR: begin
							word_q  <= AW'(page_q >> bpfa_pkg::WORD_SHIFT);
							state_q <= region_hit ? ST_READ : ST_RESP;
						end
						default: begin
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_READ: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (cmd_q == bpfa_pkg::CMD_TEST || at_last_word ||
					    (cmd_q == bpfa_pkg::CMD_ALLOC && found)) begin
						state_q <= ST_RESP;
					end else begin
						word_q  <= word_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command, bounds and result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q   <= command;
			page_q  <= base_address[AddrW-1:Shift];
			count_q <= count_in;
		end
		if (state_q == ST_PREP) begin
			res_addr_q <= '0;
			res_used_q <= 1'b0;
			case (cmd_q) inside
				bpfa_pkg::CMD_ALLOC: begin
					res_status_q <= bpfa_pkg::STAT_OOM;
					first_q      <= '0;
					last_q       <= PIW'(tot_e - 1'b1);
				end
				bpfa_pkg::CMD_TEST: begin
					res_status_q <= page_out ? bpfa_pkg::STAT_RANGE : bpfa_pkg::STAT_OK;
					first_q      <= PIW'(page_q);
					last_q       <= PIW'(page_q);
				end
				bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_SET, bpfa_pkg::CMD_CLEAR: begin
					res_status_q <= region_over ? bpfa_pkg::STAT_RANGE : bpfa_pkg::STAT_OK;
					first_q      <= PIW'(page_q);
					last_q       <= PIW'(stop_e - 1'b1);
				end
				bpfa_pkg::CMD_RESERVE: begin
					res_status_q <= bpfa_pkg::STAT_OK;
					first_q      <= PIW'(page_q);
					last_q       <= PIW'(stop_e - 1'b1);
				end
				default: begin
					res_status_q <= bpfa_pkg::STAT_OK;
				end
			endcase
		end
		if (state_q == ST_MOD) begin
			if (cmd_q == bpfa_pkg::CMD_ALLOC && found) begin
				res_addr_q   <= AddrW'({word_q, free_idx}) << Shift;
				res_status_q <= bpfa_pkg::STAT_OK;
			end
			if (cmd_q == bpfa_pkg::CMD_TEST) begin
				res_used_q <= rdata_q[first_q[bpfa_pkg::WORD_SHIFT-1:0]];
			end
		end
		if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
			out_used_q   <= res_used_q;
		end
	end

	// A taken word makes the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block still ready after taking a word");

	// Scans never walk past the last word of the range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_MOD) |-> (word_q <= last_w))
		else $error("bitmap word index beyond end of range");

	// A result is only presented out of the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result presented outside response state");

endmodule
